FILE: design/i2cms_pkg.sv
// Shared constants, types and helpers for the I2C master transaction sequencer.
package i2cms_pkg;

	// Sizes of the slot table and the byte store.
	localparam int OP_SLOTS    = 4;
	localparam int STORE_DEPTH = 64;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	localparam int NS_W        = $clog2(OP_SLOTS + 1);

	// Request opcodes.
	localparam logic [2:0] OP_SLOT_WR  = 3'd0;
	localparam logic [2:0] OP_STORE_WR = 3'd1;
	localparam logic [2:0] OP_START    = 3'd2;
	localparam logic [2:0] OP_EVENT    = 3'd3;
	localparam logic [2:0] OP_STORE_RD = 3'd4;

	// Slot modes.
	localparam logic [1:0] MODE_EMPTY = 2'd0;
	localparam logic [1:0] MODE_SEND  = 2'd1;
	localparam logic [1:0] MODE_RECV  = 2'd2;

	// Bus actions.
	localparam logic [2:0] ACT_NONE      = 3'd0;
	localparam logic [2:0] ACT_START     = 3'd1;
	localparam logic [2:0] ACT_SEND      = 3'd2;
	localparam logic [2:0] ACT_RECV_ACK  = 3'd3;
	localparam logic [2:0] ACT_RECV_NACK = 3'd4;
	localparam logic [2:0] ACT_STOP      = 3'd5;
	localparam logic [2:0] ACT_RELEASE   = 3'd6;

	// Error codes.
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_ARB      = 3'd1;
	localparam logic [2:0] ERR_ADR_NACK = 3'd2;
	localparam logic [2:0] ERR_DAT_NACK = 3'd3;
	localparam logic [2:0] ERR_NO_INFO  = 3'd4;
	localparam logic [2:0] ERR_BUS      = 3'd5;
	localparam logic [2:0] ERR_ILLEGAL  = 3'd6;

	// Bus controller status codes (master modes only).
	localparam logic [7:0] ST_BUS_ERR  = 8'h00;
	localparam logic [7:0] ST_START    = 8'h08;
	localparam logic [7:0] ST_RSTART   = 8'h10;
	localparam logic [7:0] ST_AW_ACK   = 8'h18;
	localparam logic [7:0] ST_AW_NACK  = 8'h20;
	localparam logic [7:0] ST_DW_ACK   = 8'h28;
	localparam logic [7:0] ST_DW_NACK  = 8'h30;
	localparam logic [7:0] ST_ARB_LOST = 8'h38;
	localparam logic [7:0] ST_AR_ACK   = 8'h40;
	localparam logic [7:0] ST_AR_NACK  = 8'h48;
	localparam logic [7:0] ST_DR_ACK   = 8'h50;
	localparam logic [7:0] ST_DR_NACK  = 8'h58;
	localparam logic [7:0] ST_NO_INFO  = 8'hF8;

	// One operation slot.
	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] address;
		logic [5:0] base;
		logic [6:0] length;
	} slot_t;

	// Result of the next-slot search.
	typedef struct packed {
		logic            found;
		slot_t           slot;
		logic [NS_W-1:0] next;
	} pick_t;

	// Store index from a widened value; the store wraps at its depth.
	function automatic logic [STORE_AW-1:0] store_addr(input logic [7:0] v);
		return v[STORE_AW-1:0];
	endfunction

endpackage

FILE: design/i2c_master_transaction_sequencer.sv
// Top level of the I2C master transaction sequencer.
//
// One request channel (in_valid/in_stall) carries host commands and bus status
// events; one result channel (out_valid/out_stall) returns exactly one result
// per request: the bus action, the byte to send, the last error, busy and the
// store read data. A request is taken on a clock edge with valid high and
// stall low on its channel.
// A request is decided when it is accepted: the accepting edge registers the
// decision and updates the sequencer state while the byte store is read. The
// result register then takes the decision and store data once it is free, and
// out_valid rises. One request can be accepted every cycle while the result
// channel is not stalled, since each decision is short logic. When the
// receiver stalls, the held result stays on the outputs and one more request
// is still accepted into the decision stage; after that in_stall rises until
// the result register frees up.
// Reset (arst_n low) empties all slots, clears busy, error and counters and
// drops any result in flight. The byte store is not cleared; it must be
// written before it is read.
module i2c_master_transaction_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] opcode,
	input  logic [1:0] slot_index,
	input  logic [1:0] slot_mode,
	input  logic [7:0] slot_address,
	input  logic [5:0] slot_base,
	input  logic [6:0] slot_length,
	input  logic [5:0] store_index,
	input  logic [7:0] store_data,
	input  logic [7:0] status_code,
	input  logic [7:0] bus_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] bus_action,
	output logic [7:0] send_byte,
	output logic [2:0] fault_code,
	output logic       busy_res,
	output logic [7:0] read_data
);
	import i2cms_pkg::*;

	// Sequencer state.
	slot_t            slot_q [OP_SLOTS];
	logic [NS_W-1:0]  next_q;
	logic [6:0]       done_q;
	logic [7:0]       addr_q;
	logic [5:0]       base_q;
	logic [6:0]       len_q;
	logic             run_q;
	logic [2:0]       err_q;

	// Next-state and decision values.
	logic [NS_W-1:0]     next_n;
	logic [6:0]          done_n;
	logic [7:0]          addr_n;
	logic [5:0]          base_n;
	logic [6:0]          len_n;
	logic                run_n;
	logic [2:0]          err_n;
	logic [2:0]          act_c;
	logic [7:0]          tx_c;
	logic                tx_ram_c;
	logic                rd_ram_c;
	logic                load_c;
	logic                we_c;
	logic                re_c;
	logic [STORE_AW-1:0] wa_c;
	logic [STORE_AW-1:0] ra_c;
	logic [7:0]          wd_c;
	logic [STORE_AW-1:0] pos_c;
	logic [NS_W-1:0]     pick_from;
	pick_t               pick;

	// Pipeline registers.
	logic       v_s1;
	logic [2:0] act_s1;
	logic [7:0] tx_s1;
	logic       tx_ram_s1;
	logic       rd_ram_s1;
	logic [2:0] err_s1;
	logic       busy_s1;
	logic [7:0] ram_rdata;

	logic in_acc;
	logic s2_free;
	logic s1_move;

	// Handshake: the decision stage advances whenever the result register frees up.
	assign s2_free  = !out_valid || !out_stall;
	assign s1_move  = v_s1 && s2_free;
	assign in_stall = v_s1 && !s2_free;
	assign in_acc   = in_valid && !in_stall;

	// Next-slot search starts at slot zero on a start request.
	assign pick_from = (opcode == OP_START) ? '0 : next_q;

	i2cms_slot_pick u_pick (
		.slots (slot_q),
		.from  (pick_from),
		.pick  (pick)
	);

	// Store position of the current byte within the active slot.
	assign pos_c = store_addr(8'({2'b00, base_q} + {1'b0, done_q}));

	// Decision logic for one request.
	always_comb begin
		next_n   = next_q;
		done_n   = done_q;
		addr_n   = addr_q;
		base_n   = base_q;
		len_n    = len_q;
		run_n    = run_q;
		err_n    = err_q;
		act_c    = ACT_NONE;
		tx_c     = 8'h00;
		tx_ram_c = 1'b0;
		rd_ram_c = 1'b0;
		load_c   = 1'b0;
		we_c     = 1'b0;
		re_c     = 1'b0;
		wa_c     = pos_c;
		ra_c     = pos_c;
		wd_c     = bus_byte;
		case (opcode)
			OP_STORE_WR: begin
				we_c = 1'b1;
				wa_c = store_addr({2'b00, store_index});
				wd_c = store_data;
			end
			OP_START: begin
				err_n  = ERR_NONE;
				run_n  = pick.found;
				load_c = 1'b1;
				act_c  = pick.found ? ACT_START : ACT_NONE;
			end
			OP_EVENT: begin
				case (status_code)
					ST_START, ST_RSTART: begin
						act_c = ACT_SEND;
						tx_c  = addr_q;
					end
					ST_ARB_LOST: begin
						err_n = ERR_ARB;
						run_n = 1'b0;
						act_c = ACT_RELEASE;
					end
					ST_AW_ACK, ST_DW_ACK: begin
						if (done_q < len_q) begin
							re_c     = 1'b1;
							tx_ram_c = 1'b1;
							done_n   = done_q + 7'd1;
							act_c    = ACT_SEND;
						end else begin
							load_c = 1'b1;
						end
					end
					ST_AW_NACK, ST_AR_NACK: begin
						err_n = ERR_ADR_NACK;
						run_n = 1'b0;
						act_c = ACT_STOP;
					end
					ST_DW_NACK: begin
						err_n = ERR_DAT_NACK;
						run_n = 1'b0;
						act_c = ACT_STOP;
					end
					ST_AR_ACK: begin
						act_c = ({1'b0, done_q} + 8'd1 < {1'b0, len_q}) ?
							ACT_RECV_ACK : ACT_RECV_NACK;
					end
					ST_DR_ACK: begin
						if (done_q < len_q) begin
							we_c   = 1'b1;
							done_n = done_q + 7'd1;
						end
						act_c = ({1'b0, done_n} + 8'd1 < {1'b0, len_q}) ?
							ACT_RECV_ACK : ACT_RECV_NACK;
					end
					ST_DR_NACK: begin
						if (done_q < len_q) begin
							we_c   = 1'b1;
							done_n = done_q + 7'd1;
						end
						load_c = 1'b1;
					end
					ST_NO_INFO: err_n = ERR_NO_INFO;
					ST_BUS_ERR: err_n = ERR_BUS;
					default:    err_n = ERR_ILLEGAL;
				endcase
			end
			OP_STORE_RD: begin
				re_c     = 1'b1;
				rd_ram_c = 1'b1;
				ra_c     = store_addr({2'b00, store_index});
			end
			default: begin
			end
		endcase

		// Move on to the next slot set to send or receive, or end the transaction.
		if (load_c) begin
			next_n = pick.next;
			if (pick.found) begin
				addr_n = (pick.slot.mode == MODE_SEND) ?
					(pick.slot.address & 8'hFE) : (pick.slot.address | 8'h01);
				base_n = pick.slot.base;
				len_n  = pick.slot.length;
				done_n = 7'd0;
				if (opcode == OP_EVENT) begin
					act_c = ACT_START;
				end
			end else if (opcode == OP_EVENT) begin
				run_n = 1'b0;
				act_c = ACT_STOP;
			end
		end
	end

	// Byte store.
	i2cms_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (in_acc && we_c),
		.waddr (wa_c),
		.wdata (wd_c),
		.re    (in_acc && re_c),
		.raddr (ra_c),
		.rdata (ram_rdata)
	);

	// Sequencer state registers, updated as each request is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < OP_SLOTS; i++) begin
				slot_q[i] <= '0;
			end
			next_q <= '0;
			done_q <= '0;
			addr_q <= '0;
			base_q <= '0;
			len_q  <= '0;
			run_q  <= 1'b0;
			err_q  <= ERR_NONE;
		end else if (in_acc) begin
			next_q <= next_n;
			done_q <= done_n;
			addr_q <= addr_n;
			base_q <= base_n;
			len_q  <= len_n;
			run_q  <= run_n;
			err_q  <= err_n;
			if (opcode == OP_SLOT_WR) begin
				for (int i = 0; i < OP_SLOTS; i++) begin
					if (int'(slot_index) == i) begin
						slot_q[i].mode    <= slot_mode;
						slot_q[i].address <= slot_address;
						slot_q[i].base    <= slot_base;
						slot_q[i].length  <= slot_length;
					end
				end
			end
		end
	end

	// Decision stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (s1_move) begin
			v_s1 <= 1'b0;
		end
	end

	// Decision stage payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_s1    <= act_c;
			tx_s1     <= tx_c;
			tx_ram_s1 <= tx_ram_c;
			rd_ram_s1 <= rd_ram_c;
			err_s1    <= err_n;
			busy_s1   <= run_n;
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_move) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// Result register payload; store data joins here.
	always_ff @(posedge clk) begin
		if (s1_move) begin
			bus_action <= act_s1;
			send_byte  <= tx_ram_s1 ? ram_rdata : tx_s1;
			fault_code <= err_s1;
			busy_res   <= busy_s1;
			read_data  <= rd_ram_s1 ? ram_rdata : 8'h00;
		end
	end
endmodule

FILE: design/i2cms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module i2cms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port; read data holds when not reading.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

FILE: design/i2cms_slot_pick.sv
// Finds the first operation slot set to send or receive at or after a given slot index.
module i2cms_slot_pick (
	input  i2cms_pkg::slot_t              slots [i2cms_pkg::OP_SLOTS],
	input  logic [i2cms_pkg::NS_W-1:0]    from,
	output i2cms_pkg::pick_t              pick
);
	import i2cms_pkg::*;

	// Scan from the top down so the lowest qualifying slot wins.
	always_comb begin
		pick.found = 1'b0;
		pick.slot  = slots[0];
		pick.next  = NS_W'(OP_SLOTS);
		for (int i = OP_SLOTS - 1; i >= 0; i--) begin
			if (int'(from) <= i &&
			    (slots[i].mode == MODE_SEND || slots[i].mode == MODE_RECV)) begin
				pick.found = 1'b1;
				pick.slot  = slots[i];
				pick.next  = NS_W'(i + 1);
			end
		end
	end
endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the I2C master transaction sequencer.
module tb_top;
	import i2cms_pkg::*;

	localparam int HOLD_CYCLES     = 80;
	localparam int QUIET_LIMIT     = 2000;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int FLOW_STEP_LIMIT = 300;

	// Codes outside the package that the stimulus uses on purpose.
	localparam logic [1:0] MODE_UNUSED   = 2'd3;
	localparam logic [7:0] ST_SLAVE_SLAW = 8'h60;
	localparam logic [7:0] ST_UNDEFINED  = 8'hFF;

	// One host request as it appears on the input ports.
	typedef struct packed {
		logic [2:0] opcode;
		logic [1:0] slot_index;
		logic [1:0] slot_mode;
		logic [7:0] slot_address;
		logic [5:0] slot_base;
		logic [6:0] slot_length;
		logic [5:0] store_index;
		logic [7:0] store_data;
		logic [7:0] status_code;
		logic [7:0] bus_byte;
	} host_req_t;

	// One result as it appears on the output ports.
	typedef struct packed {
		logic [2:0] action;
		logic [7:0] tx;
		logic [2:0] err;
		logic       busy;
		logic [7:0] rd;
	} bus_result_t;

	// Sequencer state as the predictor tracks it.
	typedef struct packed {
		slot_t [OP_SLOTS-1:0]        slots;
		logic [STORE_DEPTH-1:0][7:0] store;
		logic [NS_W-1:0]             nxt_slot;
		logic [6:0]                  done;
		logic [7:0]                  addr;
		logic [5:0]                  base;
		logic [6:0]                  len;
		logic                        running;
		logic [2:0]                  err;
	} seq_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	host_req_t   drv_req = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  bus_action;
	logic [7:0]  send_byte;
	logic [2:0]  fault_code;
	logic        busy_res;
	logic [7:0]  read_data;

	host_req_t   host_requests[$];
	bus_result_t awaited_results[$];
	seq_state_t  model_state = '0;
	seq_state_t  plan_state = '0;
	bus_result_t plan_result;

	int   tx_idle_pct = 26;
	int   rx_idle_pct = 71;
	bit   hold_go = 1'b0;
	int   hold_count = 0;
	logic req_fire = 1'b0;
	int   quiet_cycles = 0;
	int   errors = 0;
	int   n_checked = 0;
	int   n_items = 0;
	int   n_transactions = 0;

	i2c_master_transaction_sequencer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (drv_req.opcode),
		.slot_index   (drv_req.slot_index),
		.slot_mode    (drv_req.slot_mode),
		.slot_address (drv_req.slot_address),
		.slot_base    (drv_req.slot_base),
		.slot_length  (drv_req.slot_length),
		.store_index  (drv_req.store_index),
		.store_data   (drv_req.store_data),
		.status_code  (drv_req.status_code),
		.bus_byte     (drv_req.bus_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.bus_action   (bus_action),
		.send_byte    (send_byte),
		.fault_code   (fault_code),
		.busy_res     (busy_res),
		.read_data    (read_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Loads the next slot that is set to send or receive; returns 0 when none is left.
	function automatic logic load_slot(input seq_state_t si, output seq_state_t so);
		slot_t s;
		logic found;
		so = si;
		found = 1'b0;
		while (!found && so.nxt_slot < OP_SLOTS) begin
			s = so.slots[so.nxt_slot];
			so.nxt_slot = so.nxt_slot + 1'b1;
			if (s.mode == MODE_SEND || s.mode == MODE_RECV) begin
				so.addr = {s.address[7:1], s.mode == MODE_RECV};
				so.base = s.base;
				so.len = s.length;
				so.done = '0;
				found = 1'b1;
			end
		end
		return found;
	endfunction

	// Moves on to the next slot with a repeated start, or ends the transfer with a stop.
	function automatic logic [2:0] advance(input seq_state_t si, output seq_state_t so);
		if (load_slot(si, so))
			return ACT_START;
		so.running = 1'b0;
		return ACT_STOP;
	endfunction

	// Acknowledge the next byte only while more than one is still wanted.
	function automatic logic [2:0] recv_choice(input seq_state_t s);
		return (int'(s.done) + 1 < int'(s.len)) ? ACT_RECV_ACK : ACT_RECV_NACK;
	endfunction

	// Computes the result of one request and the sequencer state after it.
	function automatic bus_result_t sequencer_step(input host_req_t r, input seq_state_t si,
			output seq_state_t so);
		bus_result_t res;
		logic [5:0] pos;
		so = si;
		res = '0;
		pos = so.base + so.done[5:0];
		case (r.opcode)
			OP_SLOT_WR: begin
				so.slots[r.slot_index] = {r.slot_mode, r.slot_address, r.slot_base, r.slot_length};
			end
			OP_STORE_WR: so.store[r.store_index] = r.store_data;
			OP_STORE_RD: res.rd = so.store[r.store_index];
			OP_START: begin
				so.err = ERR_NONE;
				so.nxt_slot = '0;
				so.running = load_slot(so, so);
				res.action = so.running ? ACT_START : ACT_NONE;
			end
			OP_EVENT: begin
				case (r.status_code)
					ST_START, ST_RSTART: begin
						res.action = ACT_SEND;
						res.tx = so.addr;
					end
					ST_ARB_LOST: begin
						so.err = ERR_ARB;
						so.running = 1'b0;
						res.action = ACT_RELEASE;
					end
					ST_AW_ACK, ST_DW_ACK: begin
						if (so.done < so.len) begin
							res.action = ACT_SEND;
							res.tx = so.store[pos];
							so.done = so.done + 7'd1;
						end else begin
							res.action = advance(so, so);
						end
					end
					ST_AW_NACK, ST_AR_NACK: begin
						so.err = ERR_ADR_NACK;
						so.running = 1'b0;
						res.action = ACT_STOP;
					end
					ST_DW_NACK: begin
						so.err = ERR_DAT_NACK;
						so.running = 1'b0;
						res.action = ACT_STOP;
					end
					ST_AR_ACK: res.action = recv_choice(so);
					ST_DR_ACK, ST_DR_NACK: begin
						// Bytes beyond the slot length are dropped.
						if (so.done < so.len) begin
							so.store[pos] = r.bus_byte;
							so.done = so.done + 7'd1;
						end
						if (r.status_code == ST_DR_ACK)
							res.action = recv_choice(so);
						else
							res.action = advance(so, so);
					end
					ST_NO_INFO: so.err = ERR_NO_INFO;
					ST_BUS_ERR: so.err = ERR_BUS;
					default: so.err = ERR_ILLEGAL;
				endcase
			end
			default: ;
		endcase
		res.err = so.err;
		res.busy = so.running;
		return res;
	endfunction

	// Driver: offers queued requests at the falling edge and holds each one until taken.
	always @(negedge clk) begin
		if (!in_valid || req_fire) begin
			if (host_requests.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				drv_req <= host_requests.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stalls at random, with one long hold-off once the last phase begins.
	always @(negedge clk) begin
		if (hold_go && hold_count < HOLD_CYCLES) begin
			out_stall <= 1'b1;
			hold_count <= hold_count + 1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Monitor: predicts each accepted request and checks each accepted result.
	always @(posedge clk) begin
		bus_result_t got;
		bus_result_t want;
		if (arst_n) begin
			req_fire <= in_valid && !in_stall;
			if (in_valid && !in_stall)
				awaited_results.push_back(sequencer_step(drv_req, model_state, model_state));
			if (out_valid && !out_stall) begin
				got = {bus_action, send_byte, fault_code, busy_res, read_data};
				if (awaited_results.size() == 0) begin
					errors++;
					$display("%0t: result with none expected, actual action %0d error %0d",
						$time, bus_action, fault_code);
				end else begin
					want = awaited_results.pop_front();
					n_checked++;
					check_field("bus_action", want.action, got.action);
					check_field("send_byte", want.tx, got.tx);
					check_field("fault_code", want.err, got.err);
					check_field("busy_res", want.busy, got.busy);
					check_field("read_data", want.rd, got.rd);
				end
			end
			// Watchdog on cycles in which neither channel moves.
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Runs a request through the planning copy of the sequencer and queues it.
	task automatic issue(input host_req_t r);
		plan_result = sequencer_step(r, plan_state, plan_state);
		host_requests.push_back(r);
		n_items++;
	endtask

	function automatic host_req_t rand_req(input logic [2:0] op);
		host_req_t r;
		r.opcode       = op;
		r.slot_index   = 2'($urandom);
		r.slot_mode    = 2'($urandom);
		r.slot_address = 8'($urandom);
		r.slot_base    = 6'($urandom);
		r.slot_length  = 7'($urandom_range(64));
		r.store_index  = 6'($urandom);
		r.store_data   = 8'($urandom);
		r.status_code  = 8'($urandom);
		r.bus_byte     = 8'($urandom);
		return r;
	endfunction

	function automatic host_req_t bus_event(input logic [7:0] code);
		host_req_t r;
		r = rand_req(OP_EVENT);
		r.status_code = code;
		return r;
	endfunction

	function automatic host_req_t slot_cmd(input logic [1:0] idx, input logic [1:0] mode,
			input logic [7:0] adr, input logic [5:0] base, input logic [6:0] len);
		host_req_t r;
		r = rand_req(OP_SLOT_WR);
		r.slot_index = idx;
		r.slot_mode = mode;
		r.slot_address = adr;
		r.slot_base = base;
		r.slot_length = len;
		return r;
	endfunction

	// Random slot, mostly send or receive, short unless a long transfer is wanted.
	function automatic host_req_t rand_slot(input logic [1:0] idx, input bit long_xfer);
		host_req_t r;
		int pick;
		r = rand_req(OP_SLOT_WR);
		r.slot_index = idx;
		pick = $urandom_range(9);
		r.slot_mode = (pick < 4) ? MODE_SEND : (pick < 8) ? MODE_RECV :
			(pick == 8) ? MODE_EMPTY : MODE_UNUSED;
		r.slot_length = long_xfer ? 7'($urandom_range(56, 64)) : 7'($urandom_range(5));
		return r;
	endfunction

	function automatic bit is_master_code(input logic [7:0] code);
		return (code[2:0] == 3'd0) && (code <= ST_DR_NACK || code == ST_NO_INFO);
	endfunction

	// Answers each bus action with the status the bus controller would report next.
	task automatic bus_flow(input bit noisy);
		logic [2:0] act;
		logic [7:0] tx_last;
		logic [7:0] code;
		bit adr_sent;
		int steps;
		act = plan_result.action;
		tx_last = plan_result.tx;
		adr_sent = 1'b0;
		steps = 0;
		while (steps < FLOW_STEP_LIMIT && (act == ACT_START || act == ACT_SEND ||
				act == ACT_RECV_ACK || act == ACT_RECV_NACK)) begin
			steps++;
			// Requests that leave the transfer where it stands.
			if (noisy && $urandom_range(99) < 6) begin
				case ($urandom_range(4))
					0: issue(rand_req(OP_STORE_RD));
					1: issue(rand_req(OP_STORE_WR));
					2: issue(rand_req(3'($urandom_range(OP_STORE_RD + 1, 7))));
					3: issue(bus_event($urandom_range(1) ? ST_NO_INFO : ST_BUS_ERR));
					default: begin
						do code = 8'($urandom); while (is_master_code(code));
						issue(bus_event(code));
					end
				endcase
			end
			if (noisy && $urandom_range(99) < 3) begin
				// Broken sequence: lost arbitration, restart, slot rewrite or a stray ack.
				case ($urandom_range(3))
					0: issue(bus_event(ST_ARB_LOST));
					1: issue(rand_req(OP_START));
					2: issue(rand_slot(2'($urandom), 1'b0));
					default: issue(bus_event(ST_DW_ACK));
				endcase
				if (plan_result.action != ACT_NONE) begin
					act = plan_result.action;
					tx_last = plan_result.tx;
				end
				adr_sent = 1'b0;
			end else begin
				case (act)
					ACT_START: begin
						code = $urandom_range(1) ? ST_START : ST_RSTART;
						adr_sent = 1'b1;
					end
					ACT_SEND: begin
						if (adr_sent) begin
							adr_sent = 1'b0;
							if (tx_last[0])
								code = ($urandom_range(99) < 8) ? ST_AR_NACK : ST_AR_ACK;
							else
								code = ($urandom_range(99) < 8) ? ST_AW_NACK : ST_AW_ACK;
						end else begin
							code = ($urandom_range(99) < 5) ? ST_DW_NACK : ST_DW_ACK;
						end
					end
					ACT_RECV_ACK: code = ST_DR_ACK;
					default: code = ($urandom_range(99) < 15) ? ST_DR_ACK : ST_DR_NACK;
				endcase
				issue(bus_event(code));
				act = plan_result.action;
				tx_last = plan_result.tx;
			end
		end
	endtask

	// Fills the slots (some keep their old contents), starts and runs the bus exchange.
	task automatic run_transaction(input bit long_xfer);
		int long_idx;
		long_idx = $urandom_range(OP_SLOTS - 1);
		for (int i = 0; i < OP_SLOTS; i++)
			if (long_xfer ? (i == long_idx) : ($urandom_range(99) < 70))
				issue(rand_slot(2'(i), long_xfer));
		repeat ($urandom_range(2)) issue(rand_req(OP_STORE_WR));
		issue(rand_req(OP_START));
		n_transactions++;
		bus_flow(1'b1);
	endtask

	task automatic random_phase(input int quota);
		int first;
		first = n_items;
		while (n_items - first < quota) begin
			case ($urandom_range(9))
				0: issue(rand_req(OP_STORE_RD));
				1: issue(bus_event(8'($urandom)));
				default: run_transaction($urandom_range(14) == 0);
			endcase
		end
	endtask

	task automatic drain();
		while (host_requests.size() != 0 || awaited_results.size() != 0 || in_valid)
			@(posedge clk);
	endtask

	// Stimulus: reset, store fill, directed cases, then three random phases.
	initial begin
		host_req_t r;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Write every store entry first so that no read ever hits an unwritten one.
		for (int i = 0; i < STORE_DEPTH; i++) begin
			r = rand_req(OP_STORE_WR);
			r.store_index = 6'(i);
			issue(r);
		end

		// Start with no slots, then status events while idle, slave and undefined codes.
		issue(rand_req(OP_START));
		issue(bus_event(ST_AW_ACK));
		issue(bus_event(ST_NO_INFO));
		issue(bus_event(ST_BUS_ERR));
		issue(bus_event(ST_SLAVE_SLAW));
		issue(bus_event(ST_UNDEFINED));
		for (int k = OP_STORE_RD + 1; k < 8; k++)
			issue(rand_req(3'(k)));
		r = rand_req(OP_STORE_RD);
		r.store_index = '0;
		issue(r);
		r.store_index = '1;
		issue(r);

		// A send that wraps the store, a skipped unused slot, then a receive at the top.
		issue(slot_cmd(2'd0, MODE_SEND, 8'hFF, 6'd62, 7'd3));
		issue(slot_cmd(2'd1, MODE_UNUSED, 8'h00, 6'd0, 7'd1));
		issue(slot_cmd(2'd2, MODE_RECV, 8'h00, 6'd63, 7'd2));
		issue(slot_cmd(2'd3, MODE_EMPTY, 8'hAA, 6'd0, 7'd64));
		issue(rand_req(OP_START));
		n_transactions++;
		bus_flow(1'b0);

		random_phase(ITEMS_PER_PHASE);
		drain();
		tx_idle_pct = 71;
		rx_idle_pct = 26;
		random_phase(ITEMS_PER_PHASE);
		drain();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_go = 1'b1;
		random_phase(ITEMS_PER_PHASE);
		drain();
		repeat (10) @(posedge clk);

		$display("Ran %0d requests over %0d transactions; %0d results checked, %0d mismatches.",
			n_items, n_transactions, n_checked, errors);
		$display("Idle mixes covered: slow receiver, slow sender, none with a long receiver hold.");
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
